// ===== src/osm_pkg.sv =====
package osm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [1:0] {
    ACT_DATA  = 2'd0,
    ACT_PULL  = 2'd1,
    ACT_SLOT  = 2'd2,
    ACT_PILOT = 2'd3
  } action_t;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SIZE_LOG2  = 2'd0;
  localparam cfg_idx_t CFG_GUARD_LEN  = 2'd1;
  localparam cfg_idx_t CFG_DATA_COUNT = 2'd2;

  localparam int CFG_DATA_BITS = 11;

  typedef struct packed {
    action_t     action;
    sample_t     sample_re;
    sample_t     sample_im;
    logic [9:0]  slot_index;
    logic [9:0]  carrier_index;
    logic        pilot_on;
  } in_item_t;

  typedef struct packed {
    sample_t out_re;
    sample_t out_im;
    logic    out_valid;
    logic    symbol_end;
    logic    status;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic clear_wr;
    logic data_wr;
    logic pilot_rd;
    logic copy_rd;
    logic fft;
    logic bf_wa;
    logic bf_wb;
    logic finish;
    logic drain;
    logic emit;
    logic emit_drop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic completes;
    logic ready;
    logic bf_last;
    logic stage_last;
  } dp_status_t;

endpackage

// ===== src/osm_ram.sv =====
module osm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== src/osm_twiddle_rom.sv =====
module osm_twiddle_rom
  import osm_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic                            clk,
  input  logic [$clog2(MAX_POINTS)-2:0]   tw_idx,
  output sample_t                         w_re_r,
  output sample_t                         w_im_r
);

  localparam int AW      = $clog2(MAX_POINTS);
  localparam int QUARTER = MAX_POINTS / 4;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] DENOM [12] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
                                         64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};
  localparam logic [AW-2:0] QIDX = (AW-1)'(QUARTER);

  // Sine of the first quadrant by a truncated Taylor series in Q30.
  function automatic logic [FRAC_BITS-1:0] sine_at(input int k);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    logic signed [63:0] top;
    x    = (64'(k) * TWO_PI_Q30) / 64'(MAX_POINTS);
    term = x;
    sum  = $signed(x);
    top  = (64'sd1 <<< FRAC_BITS) - 64'sd1;
    for (int n = 1; n <= 12; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / DENOM[n-1];
      if (n[0]) sum = sum - $signed(term);
      else      sum = sum + $signed(term);
    end
    if (sum < 0) sum = '0;
    r = (sum + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    if (r > top) r = top;
    return r[FRAC_BITS-1:0];
  endfunction

  logic [FRAC_BITS-1:0] sine_tab [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
    localparam logic [FRAC_BITS-1:0] VAL = sine_at(k);
    assign sine_tab[k] = VAL;
  end

  logic [AW-2:0] u_idx;
  assign u_idx = tw_idx - QIDX;

  always_ff @(posedge clk) begin
    if (tw_idx <= QIDX) begin
      w_re_r <= $signed({1'b0, sine_tab[QIDX - tw_idx]});
      w_im_r <= $signed({1'b0, sine_tab[tw_idx]});
    end else begin
      w_re_r <= -$signed({1'b0, sine_tab[u_idx]});
      w_im_r <= $signed({1'b0, sine_tab[QIDX - u_idx]});
    end
  end

endmodule

// ===== src/osm_datapath.sv =====
module osm_datapath
  import osm_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  in_item_t                              in_item,
  input  logic                                  cfg_wr,
  input  cfg_idx_t                              cfg_index,
  input  logic [CFG_DATA_BITS-1:0]              cfg_data,
  input  ctrl_cmd_t                             cmd,
  input  logic [$clog2(MAX_POINTS)-1:0]         sweep_idx,
  input  logic [$clog2($clog2(MAX_POINTS))-1:0] stage,
  input  logic [$clog2(MAX_POINTS)-2:0]         bf_idx,
  output dp_status_t                            status,
  output out_item_t                             out_item_r,
  output logic                                  out_strobe_r
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;
  localparam int SW = $clog2(AW);
  localparam int SB = SAMPLE_BITS;
  localparam logic [3:0] LG_MIN = 4'd3;
  localparam logic [3:0] LG_MAX = 4'(AW);
  localparam logic [SW-1:0] STG_TOP = SW'(AW - 1);
  localparam logic signed [SB+1:0] SAT_HI = (SB+2)'((2 ** FRAC_BITS) - 1);
  localparam logic signed [SB+1:0] SAT_LO = (SB+2)'(-(2 ** FRAC_BITS));
  localparam logic signed [2*SB:0] RND = (2*SB+1)'(2 ** (FRAC_BITS - 1));

  function automatic sample_t sat_sample(input logic signed [SB+1:0] v);
    sample_t res;
    if (v > SAT_HI)      res = sample_t'(SAT_HI[SB-1:0]);
    else if (v < SAT_LO) res = sample_t'(SAT_LO[SB-1:0]);
    else                 res = sample_t'(v[SB-1:0]);
    return res;
  endfunction

  // Configuration
  logic [3:0]               size_log2_r;
  logic [CFG_DATA_BITS-1:0] guard_len_r;
  logic [CFG_DATA_BITS-1:0] data_count_r;

  logic [3:0]    lg_eff;
  logic [CW-1:0] n_eff;
  logic [AW-1:0] bin_mask;
  logic [CW-1:0] dc_eff;
  logic [CW-1:0] guard_eff;

  always_comb begin
    if (size_log2_r < LG_MIN)      lg_eff = LG_MIN;
    else if (size_log2_r > LG_MAX) lg_eff = LG_MAX;
    else                           lg_eff = size_log2_r;
    n_eff    = CW'(1) << lg_eff;
    bin_mask = AW'(n_eff - CW'(1));
    if (data_count_r == '0)                    dc_eff = CW'(1);
    else if (int'(data_count_r) > MAX_POINTS)  dc_eff = CW'(MAX_POINTS);
    else                                       dc_eff = CW'(data_count_r);
    if (int'(guard_len_r) > int'(n_eff)) guard_eff = n_eff;
    else                                 guard_eff = CW'(guard_len_r);
  end

  // Symbol state
  logic [CW-1:0] fill_r;
  logic [CW:0]   drain_r;
  logic          ready_r;
  logic [CW-1:0] held_n_r;
  logic [CW-1:0] held_guard_r;
  in_item_t      in_q_r;
  logic [AW-1:0] sweep_d_r;
  logic          pilot_d_r;
  logic          copy_d_r;

  logic          completes;
  logic          drain_last;
  logic [AW-1:0] drain_idx;

  assign completes  = ({1'b0, fill_r} + (CW+1)'(1)) >= {1'b0, dc_eff};
  assign drain_last = (drain_r + (CW+1)'(1)) >=
                      ((CW+1)'(held_n_r) + (CW+1)'(held_guard_r));

  always_comb begin
    if (drain_r < (CW+1)'(held_guard_r)) begin
      drain_idx = AW'((CW+1)'(held_n_r) - (CW+1)'(held_guard_r) + drain_r);
    end else begin
      drain_idx = AW'(drain_r - (CW+1)'(held_guard_r));
    end
  end

  // Butterfly addressing
  logic [AW-2:0] hmask;
  logic [AW-2:0] k_low;
  logic [AW-1:0] a_addr;
  logic [AW-1:0] b_addr;
  logic [AW-2:0] tw_idx;
  logic [AW-2:0] half_n_m1;

  assign hmask     = ~({(AW-1){1'b1}} << stage);
  assign k_low     = bf_idx & hmask;
  assign a_addr    = {bf_idx & ~hmask, 1'b0} | {1'b0, k_low};
  assign b_addr    = a_addr | (AW'(1) << stage);
  assign tw_idx    = k_low << (STG_TOP - stage);
  assign half_n_m1 = (AW-1)'((n_eff >> 1) - CW'(1));

  assign status.completes  = completes;
  assign status.ready      = ready_r;
  assign status.bf_last    = bf_idx == half_n_m1;
  assign status.stage_last = 4'(stage) == (lg_eff - 4'd1);

  // Memories
  logic [AW-1:0]   slot_rd;
  logic [0:0]      flag_rd;
  logic [2*SB-1:0] pval_rd;
  logic [2*SB-1:0] spec_rd;
  logic [2*SB-1:0] ta_rd;
  logic [2*SB-1:0] tb_rd;

  logic            slot_we;
  logic            pilot_we;
  logic            flag_we;
  logic [AW-1:0]   flag_waddr;
  logic [0:0]      flag_wdata;
  logic            spec_we;
  logic [AW-1:0]   spec_waddr;
  logic [2*SB-1:0] spec_wdata;
  logic            time_we;
  logic [AW-1:0]   time_waddr;
  logic [2*SB-1:0] time_wdata;
  logic [AW-1:0]   ta_raddr;
  logic [AW-1:0]   rev_full;
  logic [AW-1:0]   rev_addr;

  assign slot_we  = cmd.take && (in_item.action == ACT_SLOT);
  assign pilot_we = cmd.take && (in_item.action == ACT_PILOT);
  assign flag_we    = cmd.clear_wr || pilot_we;
  assign flag_waddr = cmd.clear_wr ? sweep_idx : AW'(in_item.carrier_index);
  assign flag_wdata = cmd.clear_wr ? 1'b0 : in_item.pilot_on;
  assign ta_raddr   = cmd.fft ? a_addr : drain_idx;

  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = sweep_d_r[AW-1-b];
    end
    rev_addr = rev_full >> (LG_MAX - lg_eff);
  end

  always_comb begin
    spec_we    = 1'b0;
    spec_waddr = sweep_idx;
    spec_wdata = '0;
    if (cmd.clear_wr) begin
      spec_we = 1'b1;
    end else if (cmd.data_wr) begin
      spec_we    = 1'b1;
      spec_waddr = slot_rd & bin_mask;
      spec_wdata = {in_q_r.sample_re, in_q_r.sample_im};
    end else if (pilot_d_r) begin
      spec_we    = flag_rd[0];
      spec_waddr = sweep_d_r & bin_mask;
      spec_wdata = pval_rd;
    end else if (copy_d_r) begin
      spec_we    = 1'b1;
      spec_waddr = sweep_d_r;
    end
  end

  // Butterfly pipeline, free running while the addresses hold.
  sample_t a_re, a_im, b_re, b_im, w_re, w_im;
  logic signed [2*SB-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  sample_t                a_re_d_r, a_im_d_r, a_re_dd_r, a_im_dd_r;
  logic signed [SB+1:0]   tr_r, ti_r;
  sample_t                na_re_r, na_im_r, nb_re_r, nb_im_r;
  logic signed [2*SB:0]   sum_re, sum_im;
  logic signed [SB+2:0]   ap_re, ap_im, am_re, am_im;

  assign a_re = sample_t'(ta_rd[2*SB-1:SB]);
  assign a_im = sample_t'(ta_rd[SB-1:0]);
  assign b_re = sample_t'(tb_rd[2*SB-1:SB]);
  assign b_im = sample_t'(tb_rd[SB-1:0]);

  assign sum_re = (2*SB+1)'(p_rr_r) - (2*SB+1)'(p_ii_r) + RND;
  assign sum_im = (2*SB+1)'(p_ri_r) + (2*SB+1)'(p_ir_r) + RND;
  assign ap_re  = (SB+3)'(a_re_dd_r) + (SB+3)'(tr_r) + (SB+3)'(1);
  assign ap_im  = (SB+3)'(a_im_dd_r) + (SB+3)'(ti_r) + (SB+3)'(1);
  assign am_re  = (SB+3)'(a_re_dd_r) - (SB+3)'(tr_r) + (SB+3)'(1);
  assign am_im  = (SB+3)'(a_im_dd_r) - (SB+3)'(ti_r) + (SB+3)'(1);

  always_ff @(posedge clk) begin
    p_rr_r    <= w_re * b_re;
    p_ii_r    <= w_im * b_im;
    p_ri_r    <= w_re * b_im;
    p_ir_r    <= w_im * b_re;
    a_re_d_r  <= a_re;
    a_im_d_r  <= a_im;
    tr_r      <= (SB+2)'(sum_re >>> FRAC_BITS);
    ti_r      <= (SB+2)'(sum_im >>> FRAC_BITS);
    a_re_dd_r <= a_re_d_r;
    a_im_dd_r <= a_im_d_r;
    na_re_r   <= sat_sample((SB+2)'(ap_re >>> 1));
    na_im_r   <= sat_sample((SB+2)'(ap_im >>> 1));
    nb_re_r   <= sat_sample((SB+2)'(am_re >>> 1));
    nb_im_r   <= sat_sample((SB+2)'(am_im >>> 1));
  end

  always_comb begin
    time_we    = 1'b0;
    time_waddr = rev_addr;
    time_wdata = spec_rd;
    if (copy_d_r && ({1'b0, sweep_d_r} < n_eff)) begin
      time_we = 1'b1;
    end else if (cmd.bf_wa) begin
      time_we    = 1'b1;
      time_waddr = a_addr;
      time_wdata = {na_re_r, na_im_r};
    end else if (cmd.bf_wb) begin
      time_we    = 1'b1;
      time_waddr = b_addr;
      time_wdata = {nb_re_r, nb_im_r};
    end
  end

  osm_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_slot (
    .clk(clk), .wr_en(slot_we), .wr_addr(AW'(in_item.slot_index)),
    .wr_data(AW'(in_item.carrier_index)), .rd_addr(fill_r[AW-1:0]), .rd_data_r(slot_rd)
  );

  osm_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_pilot_flag (
    .clk(clk), .wr_en(flag_we), .wr_addr(flag_waddr), .wr_data(flag_wdata),
    .rd_addr(sweep_idx), .rd_data_r(flag_rd)
  );

  osm_ram #(.WIDTH(2*SB), .DEPTH(MAX_POINTS)) u_pilot_val (
    .clk(clk), .wr_en(pilot_we), .wr_addr(AW'(in_item.carrier_index)),
    .wr_data({in_item.sample_re, in_item.sample_im}), .rd_addr(sweep_idx),
    .rd_data_r(pval_rd)
  );

  osm_ram #(.WIDTH(2*SB), .DEPTH(MAX_POINTS)) u_spectrum (
    .clk(clk), .wr_en(spec_we), .wr_addr(spec_waddr), .wr_data(spec_wdata),
    .rd_addr(sweep_idx), .rd_data_r(spec_rd)
  );

  // The time buffer is kept twice so that both butterfly legs are read in the same cycle.
  osm_ram #(.WIDTH(2*SB), .DEPTH(MAX_POINTS)) u_time_a (
    .clk(clk), .wr_en(time_we), .wr_addr(time_waddr), .wr_data(time_wdata),
    .rd_addr(ta_raddr), .rd_data_r(ta_rd)
  );

  osm_ram #(.WIDTH(2*SB), .DEPTH(MAX_POINTS)) u_time_b (
    .clk(clk), .wr_en(time_we), .wr_addr(time_waddr), .wr_data(time_wdata),
    .rd_addr(b_addr), .rd_data_r(tb_rd)
  );

  osm_twiddle_rom #(.MAX_POINTS(MAX_POINTS)) u_twiddle (
    .clk(clk), .tw_idx(tw_idx), .w_re_r(w_re), .w_im_r(w_im)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_q_r <= in_item;
    end
    sweep_d_r <= sweep_idx;
    if (cmd.emit) begin
      if (cmd.drain) begin
        out_item_r.out_re     <= a_re;
        out_item_r.out_im     <= a_im;
        out_item_r.out_valid  <= 1'b1;
        out_item_r.symbol_end <= drain_last;
        out_item_r.status     <= 1'b0;
      end else begin
        out_item_r.out_re     <= '0;
        out_item_r.out_im     <= '0;
        out_item_r.out_valid  <= 1'b0;
        out_item_r.symbol_end <= 1'b0;
        out_item_r.status     <= cmd.emit_drop;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r  <= 4'd6;
      guard_len_r  <= CFG_DATA_BITS'(16);
      data_count_r <= CFG_DATA_BITS'(48);
      fill_r       <= '0;
      drain_r      <= '0;
      ready_r      <= 1'b0;
      held_n_r     <= CW'(8);
      held_guard_r <= '0;
      pilot_d_r    <= 1'b0;
      copy_d_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      pilot_d_r    <= cmd.pilot_rd;
      copy_d_r     <= cmd.copy_rd;
      out_strobe_r <= cmd.emit;
      if (cfg_wr) begin
        case (cfg_index)
          CFG_SIZE_LOG2:  size_log2_r  <= cfg_data[3:0];
          CFG_GUARD_LEN:  guard_len_r  <= cfg_data;
          CFG_DATA_COUNT: data_count_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.data_wr) begin
        fill_r <= fill_r + CW'(1);
      end
      if (cmd.finish) begin
        fill_r       <= '0;
        held_n_r     <= n_eff;
        held_guard_r <= guard_eff;
        drain_r      <= '0;
        ready_r      <= 1'b1;
      end
      if (cmd.drain) begin
        if (drain_last) begin
          drain_r <= '0;
          ready_r <= 1'b0;
        end else begin
          drain_r <= drain_r + (CW+1)'(1);
        end
      end
    end
  end

endmodule

// ===== src/osm_ctrl.sv =====
module osm_ctrl
  import osm_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  action_t                               action,
  input  dp_status_t                            dp_status,
  output logic                                  busy,
  output ctrl_cmd_t                             cmd,
  output logic [$clog2(MAX_POINTS)-1:0]         sweep_idx,
  output logic [$clog2($clog2(MAX_POINTS))-1:0] stage,
  output logic [$clog2(MAX_POINTS)-2:0]         bf_idx
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;
  localparam int SW = $clog2(AW);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DATA, S_PILOT, S_COPY, S_BF_RD, S_BF_MUL, S_BF_ADD,
    S_BF_OUT, S_BF_WA, S_BF_WB, S_FIN, S_PULL
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] stage_r, stage_nxt;
  logic [AW-2:0] bf_r, bf_nxt;

  assign busy      = state_r != S_IDLE;
  assign sweep_idx = cnt_r[AW-1:0];
  assign stage     = stage_r;
  assign bf_idx    = bf_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    stage_nxt = stage_r;
    bf_nxt    = bf_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == CW'(MAX_POINTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.take = 1'b1;
          case (action)
            ACT_DATA: begin
              if (dp_status.completes && dp_status.ready) begin
                cmd.emit      = 1'b1;
                cmd.emit_drop = 1'b1;
              end else begin
                state_nxt = S_DATA;
              end
            end
            ACT_PULL: begin
              if (dp_status.ready) state_nxt = S_PULL;
              else                 cmd.emit  = 1'b1;
            end
            default: cmd.emit = 1'b1;
          endcase
        end
      end
      S_DATA: begin
        cmd.data_wr = 1'b1;
        if (dp_status.completes) begin
          cnt_nxt   = '0;
          state_nxt = S_PILOT;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // Both sweeps end with a step that issues no read, so the delayed write lands before the next pass.
      S_PILOT: begin
        cmd.pilot_rd = !cnt_r[AW];
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r[AW]) begin
          cnt_nxt   = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy_rd = !cnt_r[AW];
        cnt_nxt     = cnt_r + CW'(1);
        if (cnt_r[AW]) begin
          cnt_nxt   = '0;
          stage_nxt = '0;
          bf_nxt    = '0;
          state_nxt = S_BF_RD;
        end
      end
      S_BF_RD: begin
        cmd.fft   = 1'b1;
        state_nxt = S_BF_MUL;
      end
      S_BF_MUL: begin
        cmd.fft   = 1'b1;
        state_nxt = S_BF_ADD;
      end
      S_BF_ADD: begin
        cmd.fft   = 1'b1;
        state_nxt = S_BF_OUT;
      end
      S_BF_OUT: begin
        cmd.fft   = 1'b1;
        state_nxt = S_BF_WA;
      end
      S_BF_WA: begin
        cmd.fft   = 1'b1;
        cmd.bf_wa = 1'b1;
        state_nxt = S_BF_WB;
      end
      S_BF_WB: begin
        cmd.fft   = 1'b1;
        cmd.bf_wb = 1'b1;
        state_nxt = S_BF_RD;
        if (dp_status.bf_last) begin
          bf_nxt = '0;
          if (dp_status.stage_last) state_nxt = S_FIN;
          else                      stage_nxt = stage_r + SW'(1);
        end else begin
          bf_nxt = bf_r + (AW-1)'(1);
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        cmd.emit   = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_PULL: begin
        cmd.drain = 1'b1;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      stage_r <= '0;
      bf_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      stage_r <= stage_nxt;
      bf_r    <= bf_nxt;
    end
  end

  a_wb_follows_wa: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bf_wa |=> cmd.bf_wb)
    else $error("butterfly upper write did not follow lower write");

  a_no_overbuild: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !dp_status.ready)
    else $error("symbol built over an undrained symbol");

  a_table_write_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (action == ACT_SLOT || action == ACT_PILOT)) |-> cmd.emit)
    else $error("table write gave no result");

  a_drain_needs_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain |-> dp_status.ready)
    else $error("drain without a stored symbol");

endmodule

// ===== src/ofdm_symbol_modulator.sv =====
// Table writes, dropped samples and pulls with no stored symbol give their result in the
// cycle after the transfer; a data sample that does not complete a symbol passes through
// S_DATA first, and a pull of a stored symbol through S_PULL. A completing sample runs the
// pilot and reorder sweeps, then each butterfly in turn on the shared unit.
// Throughput: one item at a time; busy stays high until the item's result is issued.
// Reset: synchronous, active low; a clearing pass over all MAX_POINTS entries follows with busy high.
module ofdm_symbol_modulator
  import osm_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  in_item_t                 in_item,
  output logic                     out_strobe,
  output out_item_t                out_item,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  cfg_idx_t                 cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int SW = $clog2(AW);

  ctrl_cmd_t     cmd;
  dp_status_t    dp_status;
  logic [AW-1:0] sweep_idx;
  logic [SW-1:0] stage;
  logic [AW-2:0] bf_idx;

  assign cfg_ready = 1'b1;

  osm_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .action(in_item.action),
    .dp_status(dp_status), .busy(busy), .cmd(cmd), .sweep_idx(sweep_idx),
    .stage(stage), .bf_idx(bf_idx)
  );

  osm_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cfg_wr(cfg_valid && cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sweep_idx(sweep_idx),
    .stage(stage), .bf_idx(bf_idx), .status(dp_status), .out_item_r(out_item),
    .out_strobe_r(out_strobe)
  );

endmodule

// ===== tb/ofdm_symbol_modulator_tb.sv =====
module ofdm_symbol_modulator_tb;
  import osm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP = 1024;
  localparam int QTR  = MAXP / 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_SIZE_LOG2;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  ofdm_symbol_modulator #(.MAX_POINTS(MAXP)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state.
  int sine_q[QTR+1];
  int spec_re[MAXP], spec_im[MAXP];
  int tm_re[MAXP], tm_im[MAXP];
  int slot_map[MAXP];
  bit slot_set[MAXP];
  bit pilot_mark[MAXP];
  int pilot_re[MAXP], pilot_im[MAXP];
  int fill_cnt = 0, drain_pos = 0, held_n = 8, held_g = 0;
  bit sym_ready = 1'b0;
  int reg_size = 6, reg_guard = 16, reg_count = 48;

  out_item_t pending_samples[$];
  int errors = 0;
  bit no_gap = 1'b0;

  initial forever #5 clk = ~clk;

  initial begin
    #30ms;
    $display("[ofdm_symbol_modulator] ERROR");
    $finish;
  end

  function automatic void build_sine();
    longint unsigned x, term, n;
    longint sum, r;
    for (int k = 0; k <= QTR; k++) begin
      x = (64'(k) * 64'd6746518852) / MAXP;
      term = x;
      sum = longint'(x);
      for (n = 1; n <= 12; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / ((2 * n) * (2 * n + 1));
        if (n[0]) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (sum + (64'sd1 << 14)) >>> 15;
      sine_q[k] = (r > 32767) ? 32767 : int'(r);
    end
  endfunction

  function automatic longint rshift(longint v, int s);
    v = v + (64'sd1 << (s - 1));
    if (v >= 0) return v >>> s;
    return -((-v + (64'sd1 << s) - 1) >>> s);
  endfunction

  function automatic int clamp16(longint v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : int'(v));
  endfunction

  // Pilot overlay, bit-reversed copy, radix-2 butterflies with the span doubling each stage, then a cleared spectrum.
  function automatic void transform(int lg, int n);
    int r, step, ia, ib, u;
    longint wr, wi, tr, ti, ar, ai, br, bi;
    for (int j = 0; j < MAXP; j++)
      if (pilot_mark[j]) begin
        spec_re[j & (n - 1)] = pilot_re[j];
        spec_im[j & (n - 1)] = pilot_im[j];
      end
    for (int k = 0; k < n; k++) begin
      r = 0;
      for (int b = 0; b < lg; b++) r |= ((k >> b) & 1) << (lg - 1 - b);
      tm_re[r] = spec_re[k];
      tm_im[r] = spec_im[k];
    end
    for (int half = 1; half < n; half <<= 1) begin
      step = MAXP / (2 * half);
      for (int st = 0; st < n; st += 2 * half)
        for (int k = 0; k < half; k++) begin
          u = k * step;
          if (u <= QTR) begin
            wr = sine_q[QTR - u];
            wi = sine_q[u];
          end else begin
            u = u - QTR;
            if (u > QTR) u = QTR;
            wr = -sine_q[u];
            wi = sine_q[QTR - u];
          end
          ia = st + k;
          ib = st + k + half;
          br = tm_re[ib];
          bi = tm_im[ib];
          ar = tm_re[ia];
          ai = tm_im[ia];
          tr = rshift(wr * br - wi * bi, FRAC_BITS);
          ti = rshift(wr * bi + wi * br, FRAC_BITS);
          tm_re[ia] = clamp16(rshift(ar + tr, 1));
          tm_im[ia] = clamp16(rshift(ai + ti, 1));
          tm_re[ib] = clamp16(rshift(ar - tr, 1));
          tm_im[ib] = clamp16(rshift(ai - ti, 1));
        end
    end
    for (int j = 0; j < MAXP; j++) begin
      spec_re[j] = 0;
      spec_im[j] = 0;
    end
  endfunction

  function automatic out_item_t predict_sample(in_item_t it);
    out_item_t r;
    int lg, n, cnt, bin, idx;
    bit completes;
    r = '0;
    lg = (reg_size < 3) ? 3 : ((reg_size > 10) ? 10 : reg_size);
    n = 1 << lg;
    cnt = (reg_count < 1) ? 1 : ((reg_count > MAXP) ? MAXP : reg_count);
    case (it.action)
      ACT_DATA: begin
        completes = (fill_cnt + 1 >= cnt);
        if (completes && sym_ready) begin
          r.status = 1'b1;
        end else begin
          bin = slot_map[fill_cnt % MAXP] & (n - 1);
          spec_re[bin] = it.sample_re;
          spec_im[bin] = it.sample_im;
          fill_cnt++;
          if (completes) begin
            transform(lg, n);
            fill_cnt = 0;
            held_n = n;
            held_g = (reg_guard > n) ? n : reg_guard;
            drain_pos = 0;
            sym_ready = 1'b1;
          end
        end
      end
      ACT_PULL: begin
        if (sym_ready) begin
          idx = (drain_pos < held_g) ? held_n - held_g + drain_pos : drain_pos - held_g;
          idx &= MAXP - 1;
          r.out_re = sample_t'(tm_re[idx]);
          r.out_im = sample_t'(tm_im[idx]);
          r.out_valid = 1'b1;
          drain_pos++;
          if (drain_pos >= held_n + held_g) begin
            r.symbol_end = 1'b1;
            drain_pos = 0;
            sym_ready = 1'b0;
          end
        end
      end
      ACT_SLOT: begin
        slot_map[it.slot_index] = it.carrier_index;
        slot_set[it.slot_index] = 1'b1;
      end
      default: begin
        pilot_mark[it.carrier_index] = it.pilot_on;
        pilot_re[it.carrier_index] = it.sample_re;
        pilot_im[it.carrier_index] = it.sample_im;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d v=%b end=%b st=%b", $realtime,
                 out_item.out_re, out_item.out_im, out_item.out_valid,
                 out_item.symbol_end, out_item.status);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        if (out_item.out_re !== want.out_re || out_item.out_im !== want.out_im ||
            out_item.out_valid !== want.out_valid ||
            out_item.symbol_end !== want.symbol_end || out_item.status !== want.status) begin
          $display("%0t: mismatch expected re=%0d im=%0d v=%b end=%b st=%b", $realtime,
                   want.out_re, want.out_im, want.out_valid, want.symbol_end, want.status);
          $display("%0t:          actual   re=%0d im=%0d v=%b end=%b st=%b", $realtime,
                   out_item.out_re, out_item.out_im, out_item.out_valid,
                   out_item.symbol_end, out_item.status);
          errors++;
        end
      end
    end
  end

  task automatic send(in_item_t it);
    if (!no_gap && $urandom_range(99) < 22) repeat ($urandom_range(1, 5)) @(posedge clk);
    @(posedge clk);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    pending_samples.push_back(predict_sample(it));
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only with nothing in flight.
  task automatic write_reg(cfg_idx_t idx, int value);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SIZE_LOG2: reg_size = value & 'hF;
      CFG_GUARD_LEN: reg_guard = value & 'h7FF;
      default:       reg_count = value & 'h7FF;
    endcase
  endtask

  function automatic in_item_t mk(action_t a, int re, int im, int slot, int car, bit pon);
    in_item_t it;
    it.action = a;
    it.sample_re = sample_t'(re);
    it.sample_im = sample_t'(im);
    it.slot_index = slot[9:0];
    it.carrier_index = car[9:0];
    it.pilot_on = pon;
    return it;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(9))
      0: return 32767;
      1: return -32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic pulls(int count);
    repeat (count) send(mk(ACT_PULL, $urandom, $urandom, $urandom, $urandom, 1'($urandom)));
  endtask

  // Smallest size, prefix saturated to N, count saturated to one, wrapped indices.
  task automatic test_extremes();
    write_reg(CFG_SIZE_LOG2, 0);
    write_reg(CFG_GUARD_LEN, 2047);
    write_reg(CFG_DATA_COUNT, 0);
    pulls(1);
    send(mk(ACT_SLOT, 0, 0, 0, 1023, 0));
    send(mk(ACT_PILOT, 32767, -32768, 0, 1023, 1));
    send(mk(ACT_PILOT, -32768, 32767, 1023, 5, 0));
    send(mk(ACT_PILOT, 1000, -1000, 0, 2, 1));
    send(mk(ACT_DATA, -32768, 32767, 1023, 0, 1));
    send(mk(ACT_DATA, 123, 456, 0, 0, 0));
    pulls(16);
    pulls(1);
  endtask

  // Count lowered mid-fill and prefix changed while a symbol waits to drain.
  task automatic test_latching();
    write_reg(CFG_SIZE_LOG2, 3);
    write_reg(CFG_GUARD_LEN, 0);
    write_reg(CFG_DATA_COUNT, 2047);
    for (int s = 1; s < 16; s++) send(mk(ACT_SLOT, 0, 0, s, s * 67, 0));
    repeat (3) send(mk(ACT_DATA, rand_sample(), rand_sample(), 0, 0, 0));
    write_reg(CFG_DATA_COUNT, 3);
    send(mk(ACT_DATA, rand_sample(), rand_sample(), 0, 0, 0));
    write_reg(CFG_GUARD_LEN, 5);
    pulls(8);
  endtask

  task automatic test_largest();
    write_reg(CFG_SIZE_LOG2, 15);
    write_reg(CFG_GUARD_LEN, 1024);
    write_reg(CFG_GUARD_LEN, 0);
    write_reg(CFG_DATA_COUNT, 2);
    repeat (2) send(mk(ACT_DATA, rand_sample(), rand_sample(), 0, 0, 0));
    pulls(1024);
  endtask

  task automatic test_random();
    int cnt, plen, r;
    bit paused;
    cnt = 0;
    paused = 1'b0;
    while (cnt < 870) begin
      write_reg(CFG_SIZE_LOG2, $urandom_range(0, 5));
      r = $urandom_range(99);
      write_reg(CFG_GUARD_LEN, (r < 90) ? $urandom_range(0, 40) : ((r < 95) ? 1024 : 2047));
      r = $urandom_range(99);
      write_reg(CFG_DATA_COUNT, (r < 95) ? $urandom_range(1, 12) : 0);
      plen = $urandom_range(30, 90);
      repeat (plen) begin
        no_gap = (cnt >= 250 && cnt < 550);
        if (cnt >= 600 && !paused) begin
          wait_drained();
          paused = 1'b1;
        end
        r = $urandom_range(99);
        if (sym_ready) r = (r < 85) ? 1 : ((r < 92) ? 0 : ((r < 96) ? 2 : 3));
        else r = (r < 72) ? 0 : ((r < 80) ? 1 : ((r < 90) ? 2 : 3));
        case (r)
          0: begin
            if (!slot_set[fill_cnt % MAXP]) begin
              send(mk(ACT_SLOT, $urandom, $urandom, fill_cnt, $urandom, 1'($urandom)));
              cnt++;
            end
            send(mk(ACT_DATA, rand_sample(), rand_sample(), $urandom, $urandom,
                    1'($urandom)));
          end
          1: pulls(1);
          2: send(mk(ACT_SLOT, $urandom, $urandom,
                     ($urandom_range(9) < 3) ? $urandom : $urandom_range(0, 15),
                     $urandom, 1'($urandom)));
          default: send(mk(ACT_PILOT, rand_sample(), rand_sample(), $urandom,
                           $urandom, 1'($urandom)));
        endcase
        cnt++;
      end
    end
    no_gap = 1'b0;
  endtask

  initial begin
    build_sine();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_latching();
    test_largest();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_samples.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, pending_samples.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ofdm_symbol_modulator] OK");
    end else begin
      $display("[ofdm_symbol_modulator] ERROR");
    end
    $finish;
  end

endmodule
